FILE: design/psg_pkg.sv
// Package for the programmable sound generator: register map codes, mixer
// constants and the volume table. No dependencies.
`default_nettype none

package psg_pkg;

    // Request kinds carried by req_type.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Register map (standard 16-register layout).
    localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
    localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
    localparam logic [3:0] REG_NOISE_PERIOD  = 4'd6;
    localparam logic [3:0] REG_ENABLES       = 4'd7;
    localparam logic [3:0] REG_LEVEL_A       = 4'd8;
    localparam logic [3:0] REG_LEVEL_C       = 4'd10;
    localparam logic [3:0] REG_ENV_FINE      = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

    // Widths of the voice state.
    localparam int TONE_IV_W  = 18;
    localparam int TONE_CD_W  = 20;
    localparam int ENV_IV_W   = 23;
    localparam int ENV_CD_W   = 24;
    localparam int SHIFTER_W  = 17;

    // Every countdown moves by one sample (four quarter-sample units) a tick.
    localparam logic [ENV_IV_W-1:0] INTERVAL_MIN = 23'd4;
    localparam logic [ENV_CD_W-1:0] TICK_STEP    = 24'd4;

    // Divide by three: ceil(2^17 / 3), exact for magnitudes below 2^17.
    localparam logic [16:0] DIV3_RECIP = 17'd43691;

    // Types shared by the top level and the mixer.
    typedef logic [2:0][3:0]    t_level_vec;
    typedef logic signed [15:0] t_sample;

    // Logarithmic volume table, one entry per 4-bit level.
    function automatic logic [14:0] volume_level(input logic [3:0] idx);
        logic [14:0] vol;
        case (idx)
            4'd0:    vol = 15'd0;
            4'd1:    vol = 15'd256;
            4'd2:    vol = 15'd310;
            4'd3:    vol = 15'd512;
            4'd4:    vol = 15'd621;
            4'd5:    vol = 15'd1024;
            4'd6:    vol = 15'd1241;
            4'd7:    vol = 15'd2048;
            4'd8:    vol = 15'd2482;
            4'd9:    vol = 15'd4096;
            4'd10:   vol = 15'd4964;
            4'd11:   vol = 15'd8192;
            4'd12:   vol = 15'd9929;
            4'd13:   vol = 15'd16384;
            4'd14:   vol = 15'd23170;
            4'd15:   vol = 15'd32767;
            default: vol = 15'd0;
        endcase
        return vol;
    endfunction

endpackage

`default_nettype wire

FILE: design/psg_if.sv
// Valid/ready channel interfaces for the sound generator: the request
// channel and the sample channel. No dependencies.
`default_nettype none

interface psg_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [3:0] reg_addr;
    logic [7:0] reg_data;

    modport source (output valid, output req_type, output reg_addr, output reg_data,
                    input ready);
    modport sink   (input valid, input req_type, input reg_addr, input reg_data,
                    output ready);
endinterface

interface psg_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: design/psg_interval.sv
// Period to interval scaling: round(period * mult * rate_ratio / 2^16) with a
// floor of four, mult being 32 (tone, noise) or 64 (envelope). Uses psg_pkg.
`default_nettype none

module psg_interval (
    input  wire logic        i_envelope,
    input  wire logic [15:0] i_period,
    input  wire logic [15:0] i_rate_ratio,
    output logic      [22:0] o_interval
);

    logic [31:0] product;
    logic [32:0] rounded;
    logic [22:0] scaled;

    // One 16x16 product; the factor of 32 or 64 folds into the final shift.
    assign product = i_period * i_rate_ratio;

    // Round half up, then drop the fraction bits.
    always_comb begin
        if (i_envelope) begin
            rounded = {1'b0, product} + 33'd512;
            scaled  = rounded[32:10];
        end else begin
            rounded = {1'b0, product} + 33'd1024;
            scaled  = {1'b0, rounded[32:11]};
        end
    end

    // Clamp to the minimum interval.
    assign o_interval = (scaled < psg_pkg::INTERVAL_MIN) ? psg_pkg::INTERVAL_MIN : scaled;

endmodule

`default_nettype wire

FILE: design/psg_mix.sv
// Three-voice mixer: volume lookup, signed sum and divide by three with
// truncation toward zero. Uses psg_pkg.
`default_nettype none

module psg_mix (
    input  wire psg_pkg::t_level_vec i_level,
    input  wire logic [5:0]          i_enables,
    input  wire logic [2:0]          i_tone_pol,
    input  wire logic                i_noise_pol,
    output psg_pkg::t_sample         o_sample
);

    logic signed [17:0] sum;
    logic        [16:0] mag;
    logic        [33:0] prod;
    logic        [15:0] quot;
    logic               tone_hi;
    logic               noise_hi;
    logic signed [17:0] vol;

    // Each voice adds +level, -level or nothing; a disabled source counts high.
    always_comb begin
        sum = '0;
        for (int v = 0; v < 3; v++) begin
            tone_hi  = !i_enables[v] || i_tone_pol[v];
            noise_hi = !i_enables[v+3] || i_noise_pol;
            vol      = $signed({3'b000, psg_pkg::volume_level(i_level[v])});
            if (tone_hi && noise_hi) begin
                sum = sum + vol;
            end else if (!tone_hi && !noise_hi) begin
                sum = sum - vol;
            end
        end
    end

    // Magnitude times the reciprocal of three, sign restored afterward.
    assign mag  = sum[17] ? 17'(-sum) : sum[16:0];
    assign prod = mag * psg_pkg::DIV3_RECIP;
    assign quot = prod[32:17];
    assign o_sample = sum[17] ? $signed(-quot) : $signed(quot);

endmodule

`default_nettype wire

FILE: design/programmable_sound_generator_unit.sv
// Top level of the programmable sound generator: request and sample channels,
// voice state and update logic. Uses psg_pkg, psg_if, psg_interval, psg_mix.
//
//  Channel     Direction  Handshake           Transaction contents
//  i_req       in         valid/ready         req_type, reg_addr, reg_data
//  o_smp       out        valid/ready         sample_out (one per tick)
//  i_cfg_*     in         write enable only   rate_ratio (16 bits)
//
// One transaction is taken per clock unless a tick is stalled. It is held in
// the input register, from which the single update stage applies it; a tick's
// sample is then registered in the output register.
// Reset (synchronous, active low) sets all voice state to its initial values.
// A sample not yet taken holds in the output register; a tick then waits in
// the input register, which holds off new transactions until the sample goes.
`default_nettype none

module programmable_sound_generator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    psg_req_if.sink          i_req,
    psg_smp_if.source        o_smp
);

    localparam int TIW = psg_pkg::TONE_IV_W;
    localparam int TCW = psg_pkg::TONE_CD_W;
    localparam int EIW = psg_pkg::ENV_IV_W;
    localparam int ECW = psg_pkg::ENV_CD_W;

    // Configuration and handshake registers.
    logic [15:0]       r_rate_ratio;
    logic              r_in_valid;
    logic              r_in_type;
    logic [3:0]        r_in_addr;
    logic [7:0]        r_in_data;
    logic              r_out_valid;
    psg_pkg::t_sample  r_out_sample;

    // Voice state.
    logic [7:0]                   r_tone_fine   [3];
    logic [3:0]                   r_tone_coarse [3];
    logic [7:0]                   r_env_fine,     n_env_fine;
    logic [7:0]                   r_env_coarse,   n_env_coarse;
    logic [2:0][TIW-1:0]          r_tone_iv,      n_tone_iv;
    logic [2:0][TCW-1:0]          r_tone_cd,      n_tone_cd;
    logic [2:0]                   r_tone_pol,     n_tone_pol;
    logic [TIW-1:0]               r_noise_iv,     n_noise_iv;
    logic [TCW-1:0]               r_noise_cd,     n_noise_cd;
    logic                         r_noise_pol,    n_noise_pol;
    logic [psg_pkg::SHIFTER_W-1:0] r_shifter,     n_shifter;
    logic [5:0]                   r_enables,      n_enables;
    psg_pkg::t_level_vec          r_level,        n_level;
    logic [2:0]                   r_from_env,     n_from_env;
    logic [EIW-1:0]               r_env_iv,       n_env_iv;
    logic [ECW-1:0]               r_env_cd,       n_env_cd;
    logic [3:0]                   r_env_pos,      n_env_pos;
    logic                         r_env_done,     n_env_done;
    logic [3:0]                   r_env_level,    n_env_level;
    logic [3:0]                   r_env_shape,    n_env_shape;

    logic              out_free;
    logic              proceed;
    logic              do_tick;
    logic              do_write;
    logic              in_accept;
    logic [1:0]        ch;
    logic [15:0]       period;
    logic              period_env;
    logic [EIW-1:0]    new_iv;
    psg_pkg::t_sample  mix_sample;
    logic [TCW-1:0]    tone_tmp;
    logic [TCW-1:0]    noise_tmp;
    logic [ECW-1:0]    env_tmp;
    logic [3:0]        env_lvl;
    logic              fb;
    logic              sh_cont;
    logic              sh_att;
    logic              sh_alt;
    logic              sh_hold;

    // Handshake: writes always proceed, a tick needs room in the output register.
    assign out_free    = !r_out_valid || o_smp.ready;
    assign proceed     = r_in_valid && (r_in_type == psg_pkg::REQ_WRITE || out_free);
    assign do_tick     = proceed && r_in_type == psg_pkg::REQ_TICK;
    assign do_write    = proceed && r_in_type == psg_pkg::REQ_WRITE;
    assign i_req.ready = !r_in_valid || proceed;
    assign in_accept   = i_req.valid && i_req.ready;

    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = r_out_sample;

    // Period that the current write feeds into the shared scaling unit.
    assign ch = r_in_addr[2:1];

    always_comb begin
        period_env = 1'b0;
        period     = '0;
        case (r_in_addr) inside
            [psg_pkg::REG_TONE_A_FINE:psg_pkg::REG_TONE_C_COARSE]: begin
                if (r_in_addr[0]) begin
                    period = {4'b0000, r_in_data[3:0], r_tone_fine[ch]};
                end else begin
                    period = {4'b0000, r_tone_coarse[ch], r_in_data};
                end
            end
            psg_pkg::REG_NOISE_PERIOD: begin
                period = {11'b0, r_in_data[4:0]};
            end
            psg_pkg::REG_ENV_FINE: begin
                period_env = 1'b1;
                period     = {r_env_coarse, r_in_data};
            end
            psg_pkg::REG_ENV_COARSE: begin
                period_env = 1'b1;
                period     = {r_in_data, r_env_fine};
            end
            default: begin
                period = '0;
            end
        endcase
    end

    psg_interval u_interval (
        .i_envelope   (period_env),
        .i_period     (period),
        .i_rate_ratio (r_rate_ratio),
        .o_interval   (new_iv)
    );

    psg_mix u_mix (
        .i_level     (r_level),
        .i_enables   (r_enables),
        .i_tone_pol  (r_tone_pol),
        .i_noise_pol (r_noise_pol),
        .o_sample    (mix_sample)
    );

    // Envelope shape bits and the level that the next envelope step takes.
    assign sh_cont = r_env_shape[3];
    assign sh_att  = r_env_shape[2];
    assign sh_alt  = r_env_shape[1];
    assign sh_hold = r_env_shape[0];

    always_comb begin
        if (!sh_cont && r_env_done) begin
            env_lvl = 4'd0;
        end else if (sh_hold && r_env_done) begin
            if (sh_alt) begin
                env_lvl = sh_att ? 4'd0 : 4'd15;
            end else begin
                env_lvl = r_env_level;
            end
        end else if (sh_alt && r_env_done) begin
            env_lvl = sh_att ? ~r_env_pos : r_env_pos;
        end else begin
            env_lvl = sh_att ? r_env_pos : ~r_env_pos;
        end
    end

    // Noise shifter feedback.
    assign fb = ~(r_shifter[0] ^ r_shifter[3]);

    // Next state for a tick or a register write.
    always_comb begin
        n_env_fine   = r_env_fine;
        n_env_coarse = r_env_coarse;
        n_tone_iv    = r_tone_iv;
        n_tone_cd    = r_tone_cd;
        n_tone_pol   = r_tone_pol;
        n_noise_iv   = r_noise_iv;
        n_noise_cd   = r_noise_cd;
        n_noise_pol  = r_noise_pol;
        n_shifter    = r_shifter;
        n_enables    = r_enables;
        n_level      = r_level;
        n_from_env   = r_from_env;
        n_env_iv     = r_env_iv;
        n_env_cd     = r_env_cd;
        n_env_pos    = r_env_pos;
        n_env_done   = r_env_done;
        n_env_level  = r_env_level;
        n_env_shape  = r_env_shape;
        tone_tmp     = '0;
        noise_tmp    = '0;
        env_tmp      = '0;

        if (do_tick) begin
            // Tone countdowns reload and flip when they run out.
            for (int v = 0; v < 3; v++) begin
                tone_tmp = r_tone_cd[v] - psg_pkg::TICK_STEP[TCW-1:0];
                if ($signed(tone_tmp) <= 0) begin
                    n_tone_cd[v]  = tone_tmp + {2'b00, r_tone_iv[v]};
                    n_tone_pol[v] = !r_tone_pol[v];
                end else begin
                    n_tone_cd[v]  = tone_tmp;
                end
            end

            // Noise countdown clocks the shifter.
            noise_tmp = r_noise_cd - psg_pkg::TICK_STEP[TCW-1:0];
            if ($signed(noise_tmp) <= 0) begin
                n_noise_cd = noise_tmp + {2'b00, r_noise_iv};
                n_shifter  = {fb, r_shifter[psg_pkg::SHIFTER_W-1:1]};
                if (r_shifter[1]) begin
                    n_noise_pol = !r_noise_pol;
                end
            end else begin
                n_noise_cd = noise_tmp;
            end

            // Envelope countdown moves the envelope one position.
            env_tmp = r_env_cd - psg_pkg::TICK_STEP;
            if ($signed(env_tmp) <= 0) begin
                n_env_level = env_lvl;
                for (int v = 0; v < 3; v++) begin
                    if (r_from_env[v]) begin
                        n_level[v] = env_lvl;
                    end
                end
                n_env_cd  = env_tmp + {1'b0, r_env_iv};
                n_env_pos = r_env_pos + 4'd1;
                if (r_env_pos == 4'd15) begin
                    n_env_done = !(r_env_done && sh_alt && sh_cont && !sh_hold);
                end
            end else begin
                n_env_cd = env_tmp;
            end
        end else if (do_write) begin
            case (r_in_addr) inside
                [psg_pkg::REG_TONE_A_FINE:psg_pkg::REG_TONE_C_COARSE]: begin
                    n_tone_iv[ch] = new_iv[TIW-1:0];
                    n_tone_cd[ch] = r_tone_cd[ch] + {2'b00, new_iv[TIW-1:0]}
                                    - {2'b00, r_tone_iv[ch]};
                end
                psg_pkg::REG_NOISE_PERIOD: begin
                    n_noise_iv  = new_iv[TIW-1:0];
                    n_noise_cd  = r_noise_cd + {2'b00, new_iv[TIW-1:0]}
                                  - {2'b00, r_noise_iv};
                    n_noise_pol = 1'b1;
                end
                psg_pkg::REG_ENABLES: begin
                    // Enables are active low; a tone that turns on restarts.
                    n_enables = ~r_in_data[5:0];
                    for (int v = 0; v < 3; v++) begin
                        if (!r_in_data[v] && !r_enables[v]) begin
                            n_tone_pol[v] = 1'b1;
                            n_tone_cd[v]  = {2'b00, r_tone_iv[v]};
                        end
                    end
                end
                [psg_pkg::REG_LEVEL_A:psg_pkg::REG_LEVEL_C]: begin
                    n_from_env[r_in_addr[1:0]] = r_in_data[4];
                    if (!r_in_data[4]) begin
                        n_level[r_in_addr[1:0]] = r_in_data[3:0];
                    end
                end
                psg_pkg::REG_ENV_FINE, psg_pkg::REG_ENV_COARSE: begin
                    if (r_in_addr == psg_pkg::REG_ENV_FINE) begin
                        n_env_fine = r_in_data;
                    end else begin
                        n_env_coarse = r_in_data;
                    end
                    n_env_iv   = new_iv;
                    n_env_cd   = {1'b0, new_iv};
                    n_env_pos  = 4'd0;
                    n_env_done = 1'b0;
                end
                psg_pkg::REG_ENV_SHAPE: begin
                    n_env_shape = r_in_data[3:0];
                end
                default: begin
                    n_env_shape = r_env_shape;
                end
            endcase
        end
    end

    // Input register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end
            if (do_tick) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_type <= i_req.req_type;
            r_in_addr <= i_req.reg_addr;
            r_in_data <= i_req.reg_data;
        end
        if (do_tick) begin
            r_out_sample <= mix_sample;
        end
    end

    // Stored tone period bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < 3; v++) begin
                r_tone_fine[v]   <= 8'd0;
                r_tone_coarse[v] <= 4'd0;
            end
        end else if (do_write && r_in_addr <= psg_pkg::REG_TONE_C_COARSE) begin
            if (r_in_addr[0]) begin
                r_tone_coarse[ch] <= r_in_data[3:0];
            end else begin
                r_tone_fine[ch] <= r_in_data;
            end
        end
    end

    // Voice state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_ratio <= 16'd1615;
            r_env_fine   <= '0;
            r_env_coarse <= '0;
            r_tone_iv    <= {3{psg_pkg::INTERVAL_MIN[TIW-1:0]}};
            r_tone_cd    <= '0;
            r_tone_pol   <= 3'b111;
            r_noise_iv   <= psg_pkg::INTERVAL_MIN[TIW-1:0];
            r_noise_cd   <= '0;
            r_noise_pol  <= 1'b1;
            r_shifter    <= '0;
            r_enables    <= '0;
            r_level      <= '0;
            r_from_env   <= '0;
            r_env_iv     <= psg_pkg::INTERVAL_MIN;
            r_env_cd     <= '0;
            r_env_pos    <= '0;
            r_env_done   <= 1'b0;
            r_env_level  <= '0;
            r_env_shape  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rate_ratio <= i_cfg_data;
            end
            r_env_fine   <= n_env_fine;
            r_env_coarse <= n_env_coarse;
            r_tone_iv    <= n_tone_iv;
            r_tone_cd    <= n_tone_cd;
            r_tone_pol   <= n_tone_pol;
            r_noise_iv   <= n_noise_iv;
            r_noise_cd   <= n_noise_cd;
            r_noise_pol  <= n_noise_pol;
            r_shifter    <= n_shifter;
            r_enables    <= n_enables;
            r_level      <= n_level;
            r_from_env   <= n_from_env;
            r_env_iv     <= n_env_iv;
            r_env_cd     <= n_env_cd;
            r_env_pos    <= n_env_pos;
            r_env_done   <= n_env_done;
            r_env_level  <= n_env_level;
            r_env_shape  <= n_env_shape;
        end
    end

endmodule

`default_nettype wire

FILE: design/psg_checker.sv
// Port-level checks for the sound generator and the bind that attaches them
// to programmable_sound_generator_unit. Depends on that module's ports and psg_pkg.
`default_nettype none

module psg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_req_type,
    input wire logic        i_smp_valid,
    input wire logic        i_smp_ready,
    input wire logic [15:0] i_smp_data
);

    // Reset empties the sample register.
    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> !i_smp_valid)
        else $error("sample valid after reset");

    // A stalled sample keeps its value.
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_smp_valid && !i_smp_ready |=> i_smp_valid && $stable(i_smp_data))
        else $error("stalled sample changed");

    // An accepted tick is followed by a valid sample once it has passed the input and output registers.
    a_tick_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_type == psg_pkg::REQ_TICK
        |=> ##1 i_smp_valid)
        else $error("tick produced no sample");

    // With the sample register empty the block never refuses a transaction.
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp_valid |-> i_req_ready)
        else $error("request stalled with empty output");

endmodule

bind programmable_sound_generator_unit psg_checker u_psg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_smp_valid (o_smp.valid),
    .i_smp_ready (o_smp.ready),
    .i_smp_data  (o_smp.sample_out)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for programmable_sound_generator_unit: register writes
// and sample ticks go in through the request channel, and each sample is checked
// against a cycle-free model of the voices. Uses psg_pkg and psg_if.
module tb_top;

    // Register numbers that the package does not name.
    localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
    localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
    localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
    localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
    localparam logic [3:0] REG_LEVEL_B       = 4'd9;
    localparam logic [3:0] REG_PORT_A        = 4'd14;
    localparam logic [3:0] REG_PORT_B        = 4'd15;

    // Bit positions in the envelope shape and level registers.
    localparam int SHAPE_HOLD = 0;
    localparam int SHAPE_ALT  = 1;
    localparam int SHAPE_ATT  = 2;
    localparam int SHAPE_CONT = 3;
    localparam int LEVEL_ENV  = 4;

    // Interval arithmetic in quarter-sample units.
    localparam int unsigned TONE_MULT  = 32;
    localparam int unsigned ENV_MULT   = 64;
    localparam int          MIN_IV     = 4;
    localparam int          TICK_UNITS = 4;

    localparam int RESET_RATE    = 1615;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic       req_type;
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
    } psg_req_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    psg_req_if req_if ();
    psg_smp_if smp_if ();

    programmable_sound_generator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_if.sink),
        .o_smp      (smp_if.source)
    );

    // Volume table used by the voice model.
    int vol_table [16] = '{0, 256, 310, 512, 621, 1024, 1241, 2048,
                           2482, 4096, 4964, 8192, 9929, 16384, 23170, 32767};

    // Voice model state.
    int unsigned rate_ratio_m;
    logic [7:0]  reg_file [16];
    int          tone_iv [3];
    int          tone_cd [3];
    bit          tone_pos [3];
    int          noise_iv;
    int          noise_cd;
    bit          noise_pos;
    logic [16:0] noise_lfsr;
    logic [5:0]  voice_on;
    logic [3:0]  voice_lvl [3];
    bit          lvl_follows_env [3];
    int          env_iv;
    int          env_cd;
    int          env_pos;
    bit          env_done;
    logic [3:0]  env_lvl;
    logic [3:0]  env_shape;

    // Traffic state.
    psg_req_t          pending_reqs [$];
    psg_req_t          offered;
    psg_pkg::t_sample  expected_samples [$];
    psg_pkg::t_sample  want;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_left;
    int                samples_seen;
    int                quiet_cycles;
    int                error_count;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void reset_voice_model();
        rate_ratio_m = RESET_RATE;
        for (int i = 0; i < 16; i++) begin
            reg_file[i] = 8'h00;
        end
        for (int v = 0; v < 3; v++) begin
            tone_iv[v] = MIN_IV;
            tone_cd[v] = 0;
            tone_pos[v] = 1'b1;
            voice_lvl[v] = 4'd0;
            lvl_follows_env[v] = 1'b0;
        end
        noise_iv = MIN_IV;
        noise_cd = 0;
        noise_pos = 1'b1;
        noise_lfsr = '0;
        voice_on = '0;
        env_iv = MIN_IV;
        env_cd = 0;
        env_pos = 0;
        env_done = 1'b0;
        env_lvl = 4'd0;
        env_shape = 4'd0;
    endfunction

    // Period scaled to quarter-sample units, rounded, at least the minimum.
    function automatic int scaled_interval(int unsigned period, int unsigned mult);
        longint unsigned prod;
        prod = period;
        prod = prod * mult * rate_ratio_m;
        prod = (prod + 64'd32768) >> 16;
        if (prod < MIN_IV) begin
            prod = MIN_IV;
        end
        return int'(prod);
    endfunction

    function automatic void apply_reg_write(logic [3:0] addr, logic [7:0] data);
        int          ch;
        int          old_iv;
        int unsigned period;
        logic [5:0]  new_on;
        reg_file[addr] = data;
        if (addr <= psg_pkg::REG_TONE_C_COARSE) begin
            // Tone period: the countdown shifts by the change of interval.
            ch = addr >> 1;
            period = {reg_file[ch * 2 + 1][3:0], reg_file[ch * 2]};
            old_iv = tone_iv[ch];
            tone_iv[ch] = scaled_interval(period, TONE_MULT);
            tone_cd[ch] += tone_iv[ch] - old_iv;
        end else if (addr == psg_pkg::REG_NOISE_PERIOD) begin
            old_iv = noise_iv;
            noise_iv = scaled_interval(data[4:0], TONE_MULT);
            noise_cd += noise_iv - old_iv;
            noise_pos = 1'b1;
        end else if (addr == psg_pkg::REG_ENABLES) begin
            // Enables are active low; a tone that turns on restarts.
            new_on = ~data[5:0];
            for (int v = 0; v < 3; v++) begin
                if (new_on[v] && !voice_on[v]) begin
                    tone_pos[v] = 1'b1;
                    tone_cd[v] = tone_iv[v];
                end
            end
            voice_on = new_on;
        end else if (addr >= psg_pkg::REG_LEVEL_A && addr <= psg_pkg::REG_LEVEL_C) begin
            ch = addr - psg_pkg::REG_LEVEL_A;
            lvl_follows_env[ch] = data[LEVEL_ENV];
            if (!data[LEVEL_ENV]) begin
                voice_lvl[ch] = data[3:0];
            end
        end else if (addr == psg_pkg::REG_ENV_FINE || addr == psg_pkg::REG_ENV_COARSE) begin
            period = {reg_file[psg_pkg::REG_ENV_COARSE], reg_file[psg_pkg::REG_ENV_FINE]};
            env_iv = scaled_interval(period, ENV_MULT);
            env_done = 1'b0;
            env_cd = env_iv;
            env_pos = 0;
        end else if (addr == psg_pkg::REG_ENV_SHAPE) begin
            env_shape = data[3:0];
        end
    endfunction

    function automatic void step_envelope();
        bit cont;
        bit att;
        bit alt;
        bit hold;
        int pos;
        cont = env_shape[SHAPE_CONT];
        att = env_shape[SHAPE_ATT];
        alt = env_shape[SHAPE_ALT];
        hold = env_shape[SHAPE_HOLD];
        pos = env_pos;
        if (!cont && env_done) begin
            env_lvl = 4'd0;
        end else if (hold && env_done) begin
            if (alt) begin
                env_lvl = att ? 4'd0 : 4'd15;
            end
        end else if (alt && env_done) begin
            env_lvl = att ? 4'(15 - pos) : 4'(pos);
        end else begin
            env_lvl = att ? 4'(pos) : 4'(15 - pos);
        end
        for (int v = 0; v < 3; v++) begin
            if (lvl_follows_env[v]) begin
                voice_lvl[v] = env_lvl;
            end
        end
        env_cd += env_iv;
        env_pos = pos + 1;
        if (env_pos > 15) begin
            env_pos = 0;
            env_done = !(env_done && alt && cont && !hold);
        end
    endfunction

    // Mix the three voices into one sample, then advance every generator.
    function automatic psg_pkg::t_sample predict_sample();
        int   sum;
        int   t;
        int   n;
        int   mixed;
        logic fb;
        sum = 0;
        for (int v = 0; v < 3; v++) begin
            t = 1;
            n = 1;
            if (voice_on[v]) begin
                t = tone_pos[v] ? 1 : -1;
            end
            if (voice_on[v + 3]) begin
                n = noise_pos ? 1 : -1;
            end
            sum += vol_table[voice_lvl[v]] * (t + n) / 2;
        end
        mixed = sum / 3;

        for (int v = 0; v < 3; v++) begin
            tone_cd[v] -= TICK_UNITS;
            if (tone_cd[v] <= 0) begin
                tone_cd[v] += tone_iv[v];
                tone_pos[v] = !tone_pos[v];
            end
        end
        noise_cd -= TICK_UNITS;
        env_cd -= TICK_UNITS;
        if (noise_cd <= 0) begin
            fb = ~(noise_lfsr[0] ^ noise_lfsr[3]);
            noise_cd += noise_iv;
            noise_lfsr = {fb, noise_lfsr[16:1]};
            if (noise_lfsr[0]) begin
                noise_pos = !noise_pos;
            end
        end
        if (env_cd <= 0) begin
            step_envelope();
        end
        return psg_pkg::t_sample'(mixed);
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Request driver: keeps an offered transaction until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                if (offered.req_type == psg_pkg::REQ_TICK) begin
                    expected_samples.push_back(predict_sample());
                end else begin
                    apply_reg_write(offered.reg_addr, offered.reg_data);
                end
            end
            if (req_if.valid && !req_if.ready) begin
                // Still waiting for the block to take the current transaction.
            end else if (pending_reqs.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                offered = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.req_type <= offered.req_type;
                req_if.reg_addr <= offered.reg_addr;
                req_if.reg_data <= offered.reg_data;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Sample monitor and ready control, with an occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.ready <= 1'b0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                samples_seen++;
                if (samples_seen % 700 == 150) begin
                    hold_left = LONG_HOLD;
                end
                if (expected_samples.size() == 0) begin
                    flag_error($sformatf("sample %0d arrived with none outstanding",
                                         smp_if.sample_out));
                end else begin
                    want = expected_samples.pop_front();
                    if (smp_if.sample_out !== want) begin
                        flag_error($sformatf("sample mismatch: expected %0d, got %0d",
                                             want, smp_if.sample_out));
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                smp_if.ready <= 1'b0;
            end else begin
                smp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (smp_if.valid && smp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_req(logic req_type, logic [3:0] addr, logic [7:0] data);
        psg_req_t item;
        item.req_type = req_type;
        item.reg_addr = addr;
        item.reg_data = data;
        pending_reqs.push_back(item);
    endtask

    // Random transaction: mostly ticks, writes biased toward short periods so
    // tones, noise and the envelope all move within a few hundred samples.
    function automatic psg_req_t make_random_req();
        psg_req_t item;
        item.req_type = ($urandom_range(0, 99) < 55) ? psg_pkg::REQ_TICK
                                                       : psg_pkg::REQ_WRITE;
        item.reg_addr = 4'($urandom_range(0, 15));
        item.reg_data = 8'($urandom_range(0, 255));
        if (item.req_type == psg_pkg::REQ_WRITE) begin
            case (item.reg_addr)
                psg_pkg::REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE: begin
                    if ($urandom_range(0, 9) < 7) begin
                        item.reg_data = 8'($urandom_range(0, 15));
                    end
                end
                REG_TONE_A_COARSE, REG_TONE_B_COARSE, psg_pkg::REG_TONE_C_COARSE: begin
                    if ($urandom_range(0, 9) < 7) begin
                        item.reg_data[3:0] = 4'd0;
                    end
                end
                psg_pkg::REG_ENV_FINE: begin
                    if ($urandom_range(0, 9) < 7) begin
                        item.reg_data = 8'($urandom_range(0, 3));
                    end
                end
                psg_pkg::REG_ENV_COARSE: begin
                    if ($urandom_range(0, 9) < 8) begin
                        item.reg_data = 8'd0;
                    end
                end
                default: begin
                end
            endcase
        end
        return item;
    endfunction

    // Queue a batch of random transactions; called just after a falling edge.
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            pending_reqs.push_back(make_random_req());
        end
    endtask

    // Wait until every transaction is taken and every sample has arrived.
    task automatic drain();
        while (pending_reqs.size() != 0 || req_if.valid || expected_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_rate(logic [15:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        rate_ratio_m = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        req_if.valid = 1'b0;
        req_if.req_type = psg_pkg::REQ_WRITE;
        req_if.reg_addr = 4'd0;
        req_if.reg_data = 8'd0;
        smp_if.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 16'd0;
        i_rst_n = 1'b0;
        hold_left = 0;
        samples_seen = 0;
        quiet_cycles = 0;
        error_count = 0;
        send_idle_pct = 20;
        recv_idle_pct = 70;
        reset_voice_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset state, fixed and envelope levels, extreme periods,
        // rising enables, stored-only registers and all voices disabled.
        push_req(psg_pkg::REQ_TICK, 4'd0, 8'd0);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_LEVEL_A, 8'h0F);
        push_req(psg_pkg::REQ_WRITE, REG_LEVEL_B, 8'h10);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_LEVEL_C, 8'h08);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_ENV_SHAPE, 8'h0E);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_ENV_FINE, 8'h01);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_ENV_COARSE, 8'h00);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_TONE_A_FINE, 8'hFF);
        push_req(psg_pkg::REQ_WRITE, REG_TONE_A_COARSE, 8'hFF);
        push_req(psg_pkg::REQ_WRITE, REG_TONE_B_FINE, 8'h00);
        push_req(psg_pkg::REQ_WRITE, REG_TONE_C_FINE, 8'h03);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_NOISE_PERIOD, 8'hFF);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_ENABLES, 8'h00);
        repeat (4) push_req(psg_pkg::REQ_TICK, 4'hF, 8'hFF);
        push_req(psg_pkg::REQ_WRITE, REG_PORT_A, 8'hA5);
        push_req(psg_pkg::REQ_WRITE, REG_PORT_B, 8'h5A);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_ENABLES, 8'h3F);
        push_req(psg_pkg::REQ_TICK, 4'd0, 8'd0);
        push_req(psg_pkg::REQ_WRITE, psg_pkg::REG_ENABLES, 8'h38);
        repeat (2) push_req(psg_pkg::REQ_TICK, 4'd0, 8'd0);
        queue_random(300);
        drain();

        write_rate(16'd1);
        queue_random(300);
        drain();

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 70;
        recv_idle_pct = 20;
        write_rate(16'hFFFF);
        queue_random(350);
        drain();

        write_rate(16'($urandom_range(1, 65535)));
        queue_random(350);
        drain();

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_rate(16'd0);
        queue_random(100);
        drain();

        write_rate(16'($urandom_range(1, 8000)));
        queue_random(300);
        drain();

        write_rate(16'(RESET_RATE));
        queue_random(300);
        drain();

        if (expected_samples.size() != 0) begin
            flag_error($sformatf("%0d samples never arrived", expected_samples.size()));
        end
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/psg_pkg.sv
design/psg_if.sv
design/psg_interval.sv
design/psg_mix.sv
design/programmable_sound_generator_unit.sv
design/psg_checker.sv
tb/tb_top.sv
